@@ src/gzhp_pkg.sv @@
// gzhp_pkg: shared types and constants of the gzip member header parser
package gzhp_pkg;

  // width of the buffer size, byte position and bytes-left counters
  localparam int unsigned SizeBits = 16;

  // result queue between the parser and the output channel
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // header constants
  localparam logic [7:0]  Magic0     = 8'h1f;
  localparam logic [7:0]  Magic1     = 8'h8b;
  localparam logic [7:0]  MethodDefl = 8'h08;
  localparam logic [7:0]  FlgResvd   = 8'hE0;
  localparam logic [7:0]  FlgExtra   = 8'h04;
  localparam logic [7:0]  FlgName    = 8'h08;
  localparam logic [7:0]  FlgComment = 8'h10;
  localparam logic [7:0]  FlgHcrc    = 8'h02;
  localparam logic [31:0] SubIdCe    = 32'h0000_4543; // 'C' then 'E'
  localparam int unsigned MinHeader  = 10;

  typedef enum logic {
    ReqStart = 1'b0,
    ReqData  = 1'b1
  } req_e;

  typedef enum logic {
    KindEntry   = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StNotGz = 2'd1,
    StEmpty = 2'd2,
    StErr   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PhIdle    = 5'd0,
    PhMagic0  = 5'd1,
    PhMagic1  = 5'd2,
    PhMethod  = 5'd3,
    PhFlags   = 5'd4,
    PhSkip6   = 5'd5,
    PhXlen0   = 5'd6,
    PhXlen1   = 5'd7,
    PhSid0    = 5'd8,
    PhSid1    = 5'd9,
    PhSlen0   = 5'd10,
    PhSlen1   = 5'd11,
    PhCnt0    = 5'd12,
    PhCnt1    = 5'd13,
    PhEntry   = 5'd14,
    PhSskip   = 5'd15,
    PhName    = 5'd16,
    PhComment = 5'd17,
    PhCrc0    = 5'd18,
    PhCrc1    = 5'd19,
    PhDone    = 5'd20
  } phase_e;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] buffer_size;
    logic [7:0]  data_byte;
  } gzhp_in_t;

  typedef struct packed {
    kind_e       result_kind;
    status_e     status;
    logic [15:0] header_length;
    logic        ce_present;
    logic [15:0] block_count;
    logic [15:0] entry_index;
    logic [31:0] entry_size;
    logic        run_last;
  } gzhp_out_t;

  // results caused by one accepted item, entry first
  typedef struct packed {
    logic      entry_valid;
    logic      verdict_valid;
    gzhp_out_t entry;
    gzhp_out_t verdict;
  } gzhp_push_t;

endpackage

@@ src/gzhp_core.sv @@
// gzhp_core: header parse state and the per-item update
module gzhp_core import gzhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  gzhp_in_t   item_i,
  output gzhp_push_t push_o
);

  localparam logic [1:0] SecExtra   = 2'd0;
  localparam logic [1:0] SecName    = 2'd1;
  localparam logic [1:0] SecComment = 2'd2;

  phase_e              phase_q, phase_d;
  logic [SizeBits-1:0] left_q, left_d;
  logic [SizeBits-1:0] pos_q, pos_d;
  logic [7:0]          flag_q, flag_d;
  logic [15:0]         extra_q, extra_d;
  logic [15:0]         fcnt_q, fcnt_d;
  logic [31:0]         asm_q, asm_d;
  logic [15:0]         seen_q, seen_d;
  logic [15:0]         total_q, total_d;
  logic                ce_q, ce_d;

  logic                not_gz;
  logic                verdict_v;
  status_e             verdict_st;
  logic                entry_v;
  logic [15:0]         entry_idx;
  logic [31:0]         entry_size;
  logic [SizeBits-1:0] size;
  logic [7:0]          b;

  // next section after the given one
  function automatic phase_e after_sec(logic [1:0] level, logic [7:0] flg);
    if (level < SecName && (flg & FlgName) != 8'h00) return PhName;
    if (level < SecComment && (flg & FlgComment) != 8'h00) return PhComment;
    if ((flg & FlgHcrc) != 8'h00) return PhCrc0;
    return PhDone;
  endfunction

  // subfield boundary: idle means overrun error
  function automatic phase_e extra_bound(logic [15:0] rem, logic [7:0] flg);
    if (rem == 16'd0) return after_sec(SecExtra, flg);
    if (rem < 16'd4) return PhIdle;
    return PhSid0;
  endfunction

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    pos_d      = pos_q;
    flag_d     = flag_q;
    extra_d    = extra_q;
    fcnt_d     = fcnt_q;
    asm_d      = asm_q;
    seen_d     = seen_q;
    total_d    = total_q;
    ce_d       = ce_q;
    not_gz     = 1'b0;
    verdict_v  = 1'b0;
    verdict_st = StOk;
    entry_v    = 1'b0;
    entry_idx  = 16'd0;
    entry_size = 32'd0;
    size       = SizeBits'(item_i.buffer_size);
    b          = item_i.data_byte;

    if (accept_i && item_i.req_type == ReqStart) begin
      phase_d = PhIdle;
      left_d  = '0;
      pos_d   = '0;
      flag_d  = '0;
      extra_d = '0;
      fcnt_d  = '0;
      asm_d   = '0;
      seen_d  = '0;
      total_d = '0;
      ce_d    = 1'b0;
      if (size == '0) begin
        verdict_v  = 1'b1;
        verdict_st = StEmpty;
      end else if (size == SizeBits'(1)) begin
        verdict_v  = 1'b1;
        verdict_st = StNotGz;
      end else if (size < SizeBits'(MinHeader)) begin
        verdict_v  = 1'b1;
        verdict_st = StErr;
      end else begin
        left_d  = size;
        phase_d = PhMagic0;
      end
    end else if (accept_i && phase_q != PhIdle && phase_q != PhDone) begin
      pos_d  = pos_q + SizeBits'(1);
      left_d = left_q - SizeBits'(1);
      if (phase_q inside {[PhSid0:PhSskip]} && extra_q != 16'd0) begin
        extra_d = extra_q - 16'd1;
      end

      unique case (phase_q)
        PhMagic0: begin
          asm_d   = {24'd0, b};
          phase_d = PhMagic1;
        end
        PhMagic1: begin
          if (asm_q != {24'd0, Magic0} || b != Magic1) begin
            phase_d = PhIdle;
            not_gz  = 1'b1;
          end else begin
            phase_d = PhMethod;
          end
        end
        PhMethod: begin
          asm_d   = {24'd0, b};
          phase_d = PhFlags;
        end
        PhFlags: begin
          flag_d = b;
          if (asm_q != {24'd0, MethodDefl} || (b & FlgResvd) != 8'h00) begin
            phase_d = PhIdle;
          end else begin
            fcnt_d  = 16'd6;
            phase_d = PhSkip6;
          end
        end
        PhSkip6: begin
          fcnt_d = fcnt_q - 16'd1;
          if (fcnt_d == 16'd0) begin
            if ((flag_q & FlgExtra) != 8'h00) phase_d = PhXlen0;
            else phase_d = after_sec(SecExtra, flag_q);
          end
        end
        PhXlen0: begin
          extra_d = {8'd0, b};
          phase_d = PhXlen1;
        end
        PhXlen1: begin
          extra_d = {b, extra_q[7:0]};
          phase_d = extra_bound(extra_d, flag_q);
        end
        PhSid0: begin
          asm_d   = {24'd0, b};
          phase_d = PhSid1;
        end
        PhSid1: begin
          asm_d   = {16'd0, b, asm_q[7:0]};
          phase_d = PhSlen0;
        end
        PhSlen0: begin
          fcnt_d  = {8'd0, b};
          phase_d = PhSlen1;
        end
        PhSlen1: begin
          fcnt_d = {b, fcnt_q[7:0]};
          if (fcnt_d > extra_d) begin
            phase_d = PhIdle;
          end else if (asm_q == SubIdCe) begin
            ce_d = 1'b1;
            // length must be 2 plus a multiple of 4
            if (fcnt_d < 16'd2 || fcnt_d[1:0] != 2'b10) phase_d = PhIdle;
            else phase_d = PhCnt0;
          end else if (fcnt_d == 16'd0) begin
            phase_d = extra_bound(extra_d, flag_q);
          end else begin
            phase_d = PhSskip;
          end
        end
        PhCnt0: begin
          total_d = {8'd0, b};
          phase_d = PhCnt1;
        end
        PhCnt1: begin
          total_d = {b, total_q[7:0]};
          if ({2'b00, fcnt_q} != 18'd2 + {total_d, 2'b00}) begin
            phase_d = PhIdle;
          end else begin
            seen_d = 16'd0;
            asm_d  = 32'd0;
            fcnt_d = 16'd0;
            if (total_d == 16'd0) phase_d = extra_bound(extra_d, flag_q);
            else phase_d = PhEntry;
          end
        end
        PhEntry: begin
          asm_d  = asm_q | (32'(b) << {fcnt_q[1:0], 3'b000});
          fcnt_d = fcnt_q + 16'd1;
          if (fcnt_q[1:0] == 2'd3) begin
            entry_v    = 1'b1;
            entry_idx  = seen_q;
            entry_size = asm_d;
            seen_d     = seen_q + 16'd1;
            asm_d      = 32'd0;
            fcnt_d     = 16'd0;
            if (seen_d == total_q) phase_d = extra_bound(extra_d, flag_q);
          end
        end
        PhSskip: begin
          fcnt_d = fcnt_q - 16'd1;
          if (fcnt_d == 16'd0) phase_d = extra_bound(extra_d, flag_q);
        end
        PhName: begin
          if (b == 8'h00) phase_d = after_sec(SecName, flag_q);
        end
        PhComment: begin
          if (b == 8'h00) phase_d = after_sec(SecComment, flag_q);
        end
        PhCrc0:  phase_d = PhCrc1;
        PhCrc1:  phase_d = PhDone;
        default: phase_d = phase_q;
      endcase

      // buffer ran out while the header still wants bytes
      if (phase_d != PhIdle && phase_d != PhDone && left_d == '0) begin
        phase_d = PhIdle;
      end

      if (phase_d == PhDone) begin
        verdict_v  = 1'b1;
        verdict_st = StOk;
      end else if (phase_d == PhIdle) begin
        verdict_v  = 1'b1;
        verdict_st = not_gz ? StNotGz : StErr;
      end
    end
  end

  always_comb begin
    push_o.entry_valid           = entry_v;
    push_o.verdict_valid         = verdict_v;
    push_o.entry.result_kind     = KindEntry;
    push_o.entry.status          = StOk;
    push_o.entry.header_length   = 16'd0;
    push_o.entry.ce_present      = ce_d;
    push_o.entry.block_count     = total_d;
    push_o.entry.entry_index     = entry_idx;
    push_o.entry.entry_size      = entry_size;
    push_o.entry.run_last        = !verdict_v;
    push_o.verdict.result_kind   = KindVerdict;
    push_o.verdict.status        = verdict_st;
    push_o.verdict.header_length = (verdict_st == StOk) ? 16'(pos_d) : 16'd0;
    push_o.verdict.ce_present    = ce_d;
    push_o.verdict.block_count   = total_d;
    push_o.verdict.entry_index   = 16'd0;
    push_o.verdict.entry_size    = 32'd0;
    push_o.verdict.run_last      = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      left_q  <= '0;
      pos_q   <= '0;
      flag_q  <= '0;
      extra_q <= '0;
      fcnt_q  <= '0;
      asm_q   <= '0;
      seen_q  <= '0;
      total_q <= '0;
      ce_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      flag_q  <= flag_d;
      extra_q <= extra_d;
      fcnt_q  <= fcnt_d;
      asm_q   <= asm_d;
      seen_q  <= seen_d;
      total_q <= total_d;
      ce_q    <= ce_d;
    end
  end

endmodule

@@ src/gzip_header_parser.sv @@
// gzip_header_parser: top level, parser core plus result queue
//
//  channel | direction | payload    | handshake
//  --------+-----------+------------+---------------------------
//  in      | input     | gzhp_in_t  | in_valid_i / in_stall_o
//  out     | output    | gzhp_out_t | out_valid_o / out_stall_i
//
// one item is accepted per cycle while in_stall_o is low; its state update finishes in that cycle
// and its zero, one or two results enter a four-entry result queue
// a result can be taken in the cycle after its item is accepted
// in_stall_o rises only when the queue holds three or more results, so an
// item that adds two always fits; a stalled output backs up into it
// rst_ni clears the parse state and empties the queue
module gzip_header_parser import gzhp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gzhp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gzhp_out_t out_data_o
);

  logic             accept;
  logic             pop;
  gzhp_push_t       push;
  gzhp_out_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] push_n;

  // room for two more results is kept at all times
  assign in_stall_o = cnt_q > QCntW'(QDepth - 2);
  assign accept     = in_valid_i && !in_stall_o;

  gzhp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push)
  );

  // output side of the queue
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    push_n = QCntW'(push.entry_valid) + QCntW'(push.verdict_valid);
    wr_d   = wr_q + QPtrW'(push_n);
    rd_d   = rd_q + QPtrW'(pop);
    cnt_d  = cnt_q + push_n - QCntW'(pop);
  end

  // entry goes in ahead of the verdict of the same item
  always_ff @(posedge clk_i) begin
    if (push.entry_valid) begin
      mem_q[wr_q] <= push.entry;
    end
    if (push.verdict_valid) begin
      mem_q[wr_q + QPtrW'(push.entry_valid)] <= push.verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ src/gzhp_checker.sv @@
// gzhp_checker: port-level assertions for the gzip header parser, with bind
module gzhp_checker import gzhp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input gzhp_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input gzhp_out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an empty-buffer start gives a verdict at once
  a_empty_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.req_type == ReqStart &&
    in_data_i.buffer_size == 16'd0 |=> out_valid_o)
    else $error("no verdict after empty start");

  // the verdict of a two-result item is already queued
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_last |=> out_valid_o)
    else $error("second result of item missing");

  // input is only held off while results are waiting
  a_stall_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty queue");

endmodule

bind gzip_header_parser gzhp_checker u_checker (.*);

@@ sim/tb_gzip_header_parser.sv @@
// tb_gzip_header_parser: self-checking testbench for the gzip member header parser
module tb_gzip_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gzhp_pkg::*;

  // running copy of the parser: tracks the header walk byte by byte and keeps
  // the results each accepted item should produce, oldest first
  class header_checker;
    phase_e      ph;
    logic [15:0] left;
    logic [15:0] pos;
    logic [15:0] cnt;
    logic [15:0] seen;
    logic [15:0] total;
    logic [7:0]  flg;
    logic [17:0] xrem;
    logic [31:0] word;
    logic        ce;
    gzhp_out_t   fresh[$];
    gzhp_out_t   results_due[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      ph    = PhIdle;
      left  = '0;
      pos   = '0;
      cnt   = '0;
      seen  = '0;
      total = '0;
      flg   = '0;
      xrem  = '0;
      word  = '0;
      ce    = 1'b0;
    endfunction

    function void emit(kind_e k, status_e st, logic [15:0] hlen, logic [15:0] idx,
                       logic [31:0] sz);
      gzhp_out_t r;
      r.result_kind   = k;
      r.status        = st;
      r.header_length = hlen;
      r.ce_present    = ce;
      r.block_count   = total;
      r.entry_index   = idx;
      r.entry_size    = sz;
      r.run_last      = 1'b0;
      fresh.push_back(r);
    endfunction

    // final verdict; only an ok header keeps its length
    function void conclude(status_e st);
      emit(KindVerdict, st, (st == StOk) ? pos : 16'd0, 16'd0, 32'd0);
      ph = (st == StOk) ? PhDone : PhIdle;
    endfunction

    // lvl: 0 after extra, 1 after name, 2 after comment
    function void next_section(int lvl);
      if (lvl < 1 && (flg & FlgName) != 0) ph = PhName;
      else if (lvl < 2 && (flg & FlgComment) != 0) ph = PhComment;
      else if ((flg & FlgHcrc) != 0) ph = PhCrc0;
      else conclude(StOk);
    endfunction

    // at a subfield boundary: done, too few bytes for a subfield head, or next one
    function void extra_edge();
      if (xrem == 0) next_section(0);
      else if (xrem < 4) conclude(StErr);
      else ph = PhSid0;
    endfunction

    function void eat_byte(logic [7:0] b);
      pos  = pos + 16'd1;
      left = left - 16'd1;
      if (ph >= PhSid0 && ph <= PhSskip && xrem != 0) xrem = xrem - 18'd1;
      case (ph)
        PhMagic0: begin
          word = {24'd0, b};
          ph   = PhMagic1;
        end
        PhMagic1: begin
          if (word != {24'd0, Magic0} || b != Magic1) conclude(StNotGz);
          else ph = PhMethod;
        end
        PhMethod: begin
          word = {24'd0, b};
          ph   = PhFlags;
        end
        PhFlags: begin
          flg = b;
          if (word != {24'd0, MethodDefl} || (b & FlgResvd) != 0) begin
            conclude(StErr);
          end else begin
            cnt = 16'd6;
            ph  = PhSkip6;
          end
        end
        PhSkip6: begin
          cnt = cnt - 16'd1;
          if (cnt == 0) begin
            if ((flg & FlgExtra) != 0) ph = PhXlen0;
            else next_section(0);
          end
        end
        PhXlen0: begin
          xrem = {10'd0, b};
          ph   = PhXlen1;
        end
        PhXlen1: begin
          xrem = xrem | {2'd0, b, 8'd0};
          extra_edge();
        end
        PhSid0: begin
          word = {24'd0, b};
          ph   = PhSid1;
        end
        PhSid1: begin
          word = word | {16'd0, b, 8'd0};
          ph   = PhSlen0;
        end
        PhSlen0: begin
          cnt = {8'd0, b};
          ph  = PhSlen1;
        end
        PhSlen1: begin
          cnt = cnt | {b, 8'd0};
          if ({2'd0, cnt} > xrem) begin
            conclude(StErr);
          end else if (word == SubIdCe) begin
            ce = 1'b1;
            // a block table is 2 + 4 * count bytes long
            if (cnt < 2 || cnt[1:0] != 2'b10) conclude(StErr);
            else ph = PhCnt0;
          end else if (cnt == 0) begin
            extra_edge();
          end else begin
            ph = PhSskip;
          end
        end
        PhCnt0: begin
          total = {8'd0, b};
          ph    = PhCnt1;
        end
        PhCnt1: begin
          total = total | {b, 8'd0};
          if (32'(cnt) != 32'd2 + 32'd4 * 32'(total)) begin
            conclude(StErr);
          end else begin
            seen = '0;
            word = '0;
            cnt  = '0;
            if (total == 0) extra_edge();
            else ph = PhEntry;
          end
        end
        PhEntry: begin
          word = word | (32'(b) << (8 * cnt[1:0]));
          cnt  = cnt + 16'd1;
          if (cnt == 4) begin
            emit(KindEntry, StOk, 16'd0, seen, word);
            seen = seen + 16'd1;
            word = '0;
            cnt  = '0;
            if (seen == total) extra_edge();
          end
        end
        PhSskip: begin
          cnt = cnt - 16'd1;
          if (cnt == 0) extra_edge();
        end
        PhName: begin
          if (b == 0) next_section(1);
        end
        PhComment: begin
          if (b == 0) next_section(2);
        end
        PhCrc0: ph = PhCrc1;
        PhCrc1: conclude(StOk);
        default: ;
      endcase
      // out of buffer while the header still wants bytes
      if (ph != PhIdle && ph != PhDone && left == 0) conclude(StErr);
    endfunction

    // returns 1 when the item reaches the parser, 0 when it is ignored
    function bit take_item(gzhp_in_t it);
      bit        live;
      gzhp_out_t r;
      fresh.delete();
      live = 1'b1;
      if (it.req_type == ReqStart) begin
        clear_state();
        if (it.buffer_size == 0) conclude(StEmpty);
        else if (it.buffer_size == 1) conclude(StNotGz);
        else if (it.buffer_size < MinHeader) conclude(StErr);
        else begin
          left = it.buffer_size;
          ph   = PhMagic0;
        end
      end else if (ph != PhIdle && ph != PhDone) begin
        eat_byte(it.data_byte);
      end else begin
        live = 1'b0;
      end
      if (fresh.size() != 0) begin
        r = fresh.pop_back();
        r.run_last = 1'b1;
        fresh.push_back(r);
      end
      foreach (fresh[i]) results_due.push_back(fresh[i]);
      return live;
    endfunction

    function void show(string tag, gzhp_out_t r);
      $display("  %s kind=%0d st=%0d hlen=%0d ce=%0d cnt=%0d idx=%0d size=%h last=%0d",
               tag, r.result_kind, r.status, r.header_length, r.ce_present,
               r.block_count, r.entry_index, r.entry_size, r.run_last);
    endfunction

    function void check_result(gzhp_out_t got);
      gzhp_out_t want;
      bit        bad;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: result with nothing expected", $realtime);
          show("got     ", got);
        end
        return;
      end
      want = results_due.pop_front();
      bad = (got.result_kind !== want.result_kind) || (got.status !== want.status) ||
            (got.header_length !== want.header_length) ||
            (got.ce_present !== want.ce_present) ||
            (got.block_count !== want.block_count) ||
            (got.entry_index !== want.entry_index) ||
            (got.entry_size !== want.entry_size) || (got.run_last !== want.run_last);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: wrong result field", $realtime);
          show("expected", want);
          show("got     ", got);
        end
      end
    endfunction

    function void leftover_check();
      if (results_due.size() != 0) begin
        errors += results_due.size();
        if (errors <= 10) $display("mismatch: %0d results never came", results_due.size());
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  gzhp_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  gzhp_out_t out_data_o;

  header_checker hdr_chk;
  // no random idling on either side while set
  bit            calm;
  // items that reached the parser, ignored data bytes left out
  int            live_items;
  // bytes of the header under construction
  logic [7:0]    hdr[$];

  gzip_header_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // receiver back-pressure, changes on the falling edge only
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 12);
  end

  // every result taken at a rising edge goes to the checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) hdr_chk.check_result(out_data_o);
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // offer one item from a falling edge and hold it until the parser takes it;
  // valid stays high afterwards so back-to-back items follow without a gap
  task automatic push_item(input gzhp_in_t it);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (hdr_chk.take_item(it)) live_items++;
    @(negedge clk_i);
  endtask

  task automatic send_start(input logic [15:0] sz);
    gzhp_in_t it;
    it.req_type    = ReqStart;
    it.buffer_size = sz;
    it.data_byte   = 8'($urandom);
    push_item(it);
  endtask

  // buffer_size is don't-care on data items, so it gets noise
  task automatic send_byte(input logic [7:0] b);
    gzhp_in_t it;
    it.req_type    = ReqData;
    it.buffer_size = 16'($urandom);
    it.data_byte   = b;
    push_item(it);
  endtask

  // sender holds off until every pending result has been taken
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (hdr_chk.pending() != 0) @(negedge clk_i);
  endtask

  // mostly well-formed gzip header with random content; a few broken fields
  function automatic void build_header();
    logic [7:0] flg;
    logic [7:0] xb[$];
    int         nsub;
    int         len;
    int         n;
    int         nfield;
    hdr.delete();
    flg = 8'($urandom) & (FlgExtra | FlgName | FlgComment | FlgHcrc | 8'h01);
    // extra subfields are where the interesting paths are, favor them
    if ($urandom_range(99) < 60) flg = flg | FlgExtra;
    if ($urandom_range(99) < 5) flg[5 + $urandom_range(2)] = 1'b1;
    hdr.push_back(($urandom_range(99) < 4) ? 8'($urandom) : Magic0);
    hdr.push_back(($urandom_range(99) < 4) ? 8'($urandom) : Magic1);
    hdr.push_back(($urandom_range(99) < 5) ? 8'($urandom) : MethodDefl);
    hdr.push_back(flg);
    // mtime, xfl, os
    repeat (6) hdr.push_back(8'($urandom));
    if ((flg & FlgExtra) != 0) begin
      nsub = $urandom_range(3);
      repeat (nsub) begin
        if ($urandom_range(1) == 1) begin
          // block table subfield
          n = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(3);
          len = 2 + 4 * n;
          nfield = n;
          if ($urandom_range(99) < 8) len += $urandom_range(1, 3);
          else if ($urandom_range(99) < 8) nfield = n + $urandom_range(1, 2);
          xb.push_back(SubIdCe[7:0]);
          xb.push_back(SubIdCe[15:8]);
          xb.push_back(8'(len));
          xb.push_back(8'(len >> 8));
          xb.push_back(8'(nfield));
          xb.push_back(8'(nfield >> 8));
          repeat (4 * n) xb.push_back(8'($urandom));
        end else begin
          len = $urandom_range(5);
          xb.push_back(8'($urandom));
          xb.push_back(8'($urandom));
          xb.push_back(8'(len));
          xb.push_back(8'(len >> 8));
          repeat (len) xb.push_back(8'($urandom));
        end
      end
      len = xb.size();
      // wrong total extra length: overrun or short tail
      if ($urandom_range(99) < 6) len += $urandom_range(1, 3);
      else if ($urandom_range(99) < 6 && len >= 3) len -= $urandom_range(1, 3);
      hdr.push_back(8'(len));
      hdr.push_back(8'(len >> 8));
      foreach (xb[i]) hdr.push_back(xb[i]);
    end
    if ((flg & FlgName) != 0) begin
      repeat ($urandom_range(6)) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'h00);
    end
    if ((flg & FlgComment) != 0) begin
      repeat ($urandom_range(6)) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'h00);
    end
    if ((flg & FlgHcrc) != 0) repeat (2) hdr.push_back(8'($urandom));
  endfunction

  // one buffer: a start then its bytes, or plain noise now and then
  task automatic run_buffer();
    int mode;
    int sz;
    int n_send;
    mode = $urandom_range(99);
    if (mode < 10) begin
      send_start(($urandom_range(1) == 1) ? 16'($urandom_range(40)) : 16'($urandom));
      repeat ($urandom_range(30)) send_byte(8'($urandom));
    end else begin
      build_header();
      if (mode < 75) sz = hdr.size() + $urandom_range(3);
      else if (mode < 90) sz = $urandom_range(10, hdr.size());  // truncated buffer
      else sz = $urandom_range(65535);
      n_send = hdr.size();
      // abandoned part way, the next start restarts the parser
      if (mode >= 95) n_send = $urandom_range(hdr.size());
      send_start(16'(sz));
      for (int i = 0; i < n_send; i++) send_byte(hdr[i]);
      // trailing bytes, mostly ignored after a verdict
      repeat ($urandom_range(2)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int buf_no;
    hdr_chk     = new();
    calm        = 1'b0;
    live_items  = 0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: byte while idle, the short buffer sizes, a minimal ok header
    // in the largest buffer, bad magic, reserved flag bits
    send_byte(8'hff);
    send_start(16'd0);
    send_start(16'd1);
    send_start(16'd2);
    send_start(16'd9);
    send_start(16'hffff);
    send_byte(Magic0);
    send_byte(Magic1);
    send_byte(MethodDefl);
    send_byte(8'h00);
    repeat (6) send_byte(8'hff);
    send_start(16'd12);
    send_byte(Magic0);
    send_byte(8'h00);
    send_start(16'd10);
    send_byte(Magic0);
    send_byte(Magic1);
    send_byte(MethodDefl);
    send_byte(FlgResvd);
    wait_drained();

    // random buffers; a stretch without idling and periodic full drains
    live_items = 0;
    buf_no     = 0;
    while (live_items < 1200) begin
      calm = (buf_no >= 20 && buf_no < 35);
      if (buf_no % 15 == 14) wait_drained();
      run_buffer();
      buf_no++;
    end
    calm = 1'b0;

    // drain, then wait on to catch stray results
    wait_drained();
    repeat (20) @(posedge clk_i);
    hdr_chk.leftover_check();
    if (hdr_chk.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
